/* rtl/lsm_pkg.sv */
// Shared types, constants and helper functions for the line substring matcher.
package lsm_pkg;

  // Fixed field widths
  localparam int unsigned LSM_BYTE_W      = 8;
  localparam int unsigned LSM_COUNT_W     = 32;
  localparam int unsigned LSM_LEN_W       = 4;
  localparam int unsigned LSM_PATTERN_W   = 64;
  localparam int unsigned LSM_CFG_IDX_W   = 1;

  // Default and largest needle size in bytes
  localparam int unsigned LSM_MAX_NEEDLE_BYTES = 8;

  // Depth of the queue between front and back
  localparam int unsigned LSM_QUEUE_DEPTH = 2;

  localparam logic [LSM_BYTE_W-1:0]  LSM_NEWLINE   = 8'd10;
  localparam logic [LSM_COUNT_W-1:0] LSM_COUNT_MAX = '1;

  // Configuration register indexes
  typedef enum logic [LSM_CFG_IDX_W-1:0] {
    REG_NEEDLE_PATTERN = 1'b0,
    REG_NEEDLE_LENGTH  = 1'b1
  } lsm_reg_t;

  // Input beat
  typedef struct packed {
    logic [LSM_BYTE_W-1:0] text_byte;
    logic                  end_of_text;
  } lsm_in_t;

  // Result beat
  typedef struct packed {
    logic                   occurrence_here;
    logic                   line_finished;
    logic                   line_had_match;
    logic [LSM_COUNT_W-1:0] line_number;
    logic [LSM_COUNT_W-1:0] total_occurrences;
  } lsm_out_t;

  // Classified byte passed from front to back
  typedef struct packed {
    logic [LSM_BYTE_W-1:0] folded;
    logic                  is_newline;
    logic                  last;
  } lsm_item_t;

  // Needle configuration seen by the back end
  typedef struct packed {
    logic [LSM_PATTERN_W-1:0] pattern;
    logic [LSM_LEN_W-1:0]     length;
  } lsm_needle_t;

  // Fold ASCII upper case letters to lower case.
  function automatic logic [LSM_BYTE_W-1:0] lsm_fold(input logic [LSM_BYTE_W-1:0] b);
    logic [LSM_BYTE_W-1:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

  // Saturating increment of a counter.
  function automatic logic [LSM_COUNT_W-1:0] lsm_sat_inc(input logic [LSM_COUNT_W-1:0] v);
    return (v == LSM_COUNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

/* rtl/lsm_front.sv */
// Front end: configuration registers, input handshake and byte classification.
module lsm_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lsm_pkg::lsm_in_t                  in_payload,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lsm_pkg::LSM_CFG_IDX_W-1:0] cfg_index,
  input  logic [lsm_pkg::LSM_PATTERN_W-1:0] cfg_data,
  input  logic                              queue_full,
  output logic                              push,
  output lsm_pkg::lsm_item_t                item,
  output lsm_pkg::lsm_needle_t              needle
);
  import lsm_pkg::*;

  logic [LSM_PATTERN_W-1:0] pattern_r;
  logic [LSM_LEN_W-1:0]     length_r;
  logic                     cfg_we;

  // Registers are always writable.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      length_r  <= LSM_LEN_W'(1);
    end else if (cfg_we) begin
      unique case (lsm_reg_t'(cfg_index))
        REG_NEEDLE_PATTERN: pattern_r <= cfg_data;
        REG_NEEDLE_LENGTH:  length_r  <= cfg_data[LSM_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign needle.pattern = pattern_r;
  assign needle.length  = length_r;

  // Take a beat whenever the queue has room.
  assign in_stall = queue_full;
  assign push     = in_valid & ~queue_full;

  // Classify the byte on its way into the queue.
  assign item.folded     = lsm_fold(in_payload.text_byte);
  assign item.is_newline = (in_payload.text_byte == LSM_NEWLINE);
  assign item.last       = in_payload.end_of_text;

endmodule

/* rtl/lsm_queue.sv */
// Short FIFO that decouples the front end from the back end.
module lsm_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lsm_pkg::lsm_item_t wr_item,
  input  logic               pop,
  output lsm_pkg::lsm_item_t rd_item,
  output logic               full,
  output logic               empty
);
  import lsm_pkg::*;

  localparam int unsigned DEPTH = LSM_QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  lsm_item_t         mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_item = mem[rd_ptr_r];

  // Storage is written at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_item;
    end
  end

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* rtl/lsm_back.sv */
// Back end: match window, counters and the registered result beat.
module lsm_back #(
  parameter int unsigned MAX_NEEDLE_BYTES = lsm_pkg::LSM_MAX_NEEDLE_BYTES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lsm_pkg::lsm_needle_t needle,
  input  lsm_pkg::lsm_item_t   item,
  input  logic                 queue_empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lsm_pkg::lsm_out_t    out_payload
);
  import lsm_pkg::*;

  localparam int unsigned FILL_W = $clog2(MAX_NEEDLE_BYTES + 1);
  localparam logic [FILL_W-1:0]    FILL_MAX = FILL_W'(MAX_NEEDLE_BYTES);
  localparam logic [LSM_LEN_W-1:0] LEN_MAX  = LSM_LEN_W'(MAX_NEEDLE_BYTES);

  logic [MAX_NEEDLE_BYTES-1:0][LSM_BYTE_W-1:0] window_r, window_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt, fill_shift;
  logic [LSM_COUNT_W-1:0] line_cnt_r, line_cnt_nxt;
  logic [LSM_COUNT_W-1:0] occ_cnt_r, occ_cnt_nxt, occ_cnt_here;
  logic                   flag_r, flag_nxt, flag_here;
  logic                   out_valid_r, out_valid_nxt;
  lsm_out_t               out_payload_r, out_payload_nxt;

  logic [LSM_LEN_W-1:0]                      eff_len;
  logic [MAX_NEEDLE_BYTES-1:0][LSM_BYTE_W-1:0] window_shift;
  logic [MAX_NEEDLE_BYTES-1:0]               byte_ok;
  logic                                      match;
  logic                                      occ;

  // Advance when a beat waits and the output register is free or draining.
  assign pop = ~queue_empty & (~out_valid_r | ~out_stall);

  // Clamp the configured length to the usable range.
  always_comb begin
    if (needle.length == '0) begin
      eff_len = LSM_LEN_W'(1);
    end else if (needle.length > LEN_MAX) begin
      eff_len = LEN_MAX;
    end else begin
      eff_len = needle.length;
    end
  end

  // Window after shifting in the new byte; slot zero is the newest.
  always_comb begin
    for (int k = MAX_NEEDLE_BYTES - 1; k > 0; k--) begin
      window_shift[k] = window_r[k-1];
    end
    window_shift[0] = item.folded;
    fill_shift = (fill_r < FILL_MAX) ? fill_r + 1'b1 : fill_r;
  end

  // Parallel compare of each window slot against its aligned needle byte.
  always_comb begin
    logic [LSM_LEN_W-1:0] pos;
    logic [LSM_PATTERN_W-1:0] shifted;
    for (int k = 0; k < MAX_NEEDLE_BYTES; k++) begin
      pos     = eff_len - LSM_LEN_W'(k + 1);
      shifted = needle.pattern >> {pos, 3'b000};
      byte_ok[k] = (LSM_LEN_W'(k) >= eff_len) ||
                   (window_shift[k] == lsm_fold(shifted[LSM_BYTE_W-1:0]));
    end
    match = (&byte_ok) && (LSM_LEN_W'(fill_shift) >= eff_len);
  end

  // Result of the current beat and the state it leaves behind.
  always_comb begin
    occ          = ~item.is_newline & match;
    occ_cnt_here = occ ? lsm_sat_inc(occ_cnt_r) : occ_cnt_r;
    flag_here    = flag_r | occ;

    out_payload_nxt.occurrence_here   = occ;
    out_payload_nxt.line_finished     = item.is_newline | item.last;
    out_payload_nxt.line_had_match    = (item.is_newline | item.last) & flag_here;
    out_payload_nxt.line_number       = line_cnt_r;
    out_payload_nxt.total_occurrences = occ_cnt_here;

    window_nxt = item.is_newline ? window_r : window_shift;
    priority if (item.last) begin
      fill_nxt     = '0;
      line_cnt_nxt = LSM_COUNT_W'(1);
      occ_cnt_nxt  = '0;
      flag_nxt     = 1'b0;
    end else if (item.is_newline) begin
      fill_nxt     = '0;
      line_cnt_nxt = lsm_sat_inc(line_cnt_r);
      occ_cnt_nxt  = occ_cnt_here;
      flag_nxt     = 1'b0;
    end else begin
      fill_nxt     = fill_shift;
      line_cnt_nxt = line_cnt_r;
      occ_cnt_nxt  = occ_cnt_here;
      flag_nxt     = flag_here;
    end
  end

  assign out_valid_nxt = pop | (out_valid_r & out_stall);

  // Window bytes carry no reset; the fill count gates every compare.
  always_ff @(posedge clk) begin
    if (pop) begin
      window_r      <= window_nxt;
      out_payload_r <= out_payload_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      line_cnt_r  <= LSM_COUNT_W'(1);
      occ_cnt_r   <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        fill_r     <= fill_nxt;
        line_cnt_r <= line_cnt_nxt;
        occ_cnt_r  <= occ_cnt_nxt;
        flag_r     <= flag_nxt;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

endmodule

/* rtl/line_substring_matcher.sv */
// Top level of the case-insensitive, line-bounded substring matcher.
//
// The block scans text at one byte per clock cycle unless a stall holds it, and
// returns one result beat per input beat, in order. A front end folds each byte
// to lower case, spots newlines and pushes the byte into a two-entry queue; the
// back end shifts it into a window of the latest MAX_NEEDLE_BYTES bytes, compares
// every position against the needle in parallel and updates the occurrence and
// line counters before loading the output register. Each byte passes through a
// queue entry and then the output register, and the input keeps flowing while a
// finished result waits, until the queue is full. Both counters saturate, and a
// beat with end_of_text set starts a fresh text on the next beat. The needle
// registers are written through the cfg port, which is always ready; write
// them only while no beat is in flight.
module line_substring_matcher #(
  parameter int unsigned MAX_NEEDLE_BYTES = lsm_pkg::LSM_MAX_NEEDLE_BYTES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lsm_pkg::lsm_in_t                  in_payload,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lsm_pkg::lsm_out_t                 out_payload,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lsm_pkg::LSM_CFG_IDX_W-1:0] cfg_index,
  input  logic [lsm_pkg::LSM_PATTERN_W-1:0] cfg_data
);
  import lsm_pkg::*;

  logic        push;
  logic        pop;
  logic        queue_full;
  logic        queue_empty;
  lsm_item_t   front_item;
  lsm_item_t   back_item;
  lsm_needle_t needle;

  // Handshake, configuration and classification.
  lsm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_payload (in_payload),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .queue_full (queue_full),
    .push       (push),
    .item       (front_item),
    .needle     (needle)
  );

  // Decoupling queue.
  lsm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (front_item),
    .pop     (pop),
    .rd_item (back_item),
    .full    (queue_full),
    .empty   (queue_empty)
  );

  // Matching and counting.
  lsm_back #(
    .MAX_NEEDLE_BYTES (MAX_NEEDLE_BYTES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .needle      (needle),
    .item        (back_item),
    .queue_empty (queue_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload)
  );

endmodule

/* rtl/lsm_checker.sv */
// Port-level checker for the line substring matcher and its bind statement.
module lsm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input lsm_pkg::lsm_out_t out_payload
);
  import lsm_pkg::*;

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload))
    else $error("result beat changed while stalled");

  // A line can only report a match when it is finished.
  a_had_needs_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.line_had_match |-> out_payload.line_finished)
    else $error("line_had_match without line_finished");

  // An occurrence here means the running total is nonzero and the line matched.
  a_occ_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.occurrence_here |->
      out_payload.total_occurrences != '0 &&
      (!out_payload.line_finished || out_payload.line_had_match))
    else $error("occurrence not reflected in total or line flag");

  // Line numbers are one-based.
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_payload.line_number != '0)
    else $error("line number is zero");

endmodule

bind line_substring_matcher lsm_checker u_lsm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_payload (out_payload)
);

/* test/tb.sv */
// Testbench for the line substring matcher: directed and random text scans checked beat by beat.
`timescale 1ns / 1ps

module tb;
  import lsm_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned MAX_PRINTED = 30;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  lsm_in_t                  in_payload;
  logic                     out_valid;
  logic                     out_stall;
  lsm_out_t                 out_payload;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [LSM_CFG_IDX_W-1:0] cfg_index;
  logic [LSM_PATTERN_W-1:0] cfg_data;

  // Scanner state as predicted by the testbench.
  logic [LSM_BYTE_W-1:0]    window_q [LSM_MAX_NEEDLE_BYTES];
  logic [LSM_LEN_W-1:0]     window_fill;
  logic [LSM_COUNT_W-1:0]   line_no;
  logic [LSM_COUNT_W-1:0]   occ_total;
  logic                     line_hit;
  logic [LSM_PATTERN_W-1:0] needle_pat;
  logic [LSM_LEN_W-1:0]     needle_size;

  lsm_out_t    scan_results_due [$];
  bit          steady;
  int unsigned hold_left;
  int unsigned rx_wait;
  int unsigned quiet_cycles;
  int unsigned fail_count;
  int unsigned beats_sent;
  int unsigned lines_ended;
  int unsigned occurrences_seen;
  int unsigned settings_used;
  int unsigned held_cycles;

  line_substring_matcher u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_payload(out_payload),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Byte handling of the scanner.
  function automatic logic [LSM_BYTE_W-1:0] to_lower(input logic [LSM_BYTE_W-1:0] c);
    return (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
  endfunction

  function automatic int unsigned needle_span();
    if (needle_size == 0) return 1;
    if (needle_size > LSM_MAX_NEEDLE_BYTES) return LSM_MAX_NEEDLE_BYTES;
    return int'(needle_size);
  endfunction

  function automatic void clear_window();
    int k;
    for (k = 0; k < LSM_MAX_NEEDLE_BYTES; k++) window_q[k] = '0;
    window_fill = '0;
  endfunction

  // Advance the predicted scanner by one text byte and return the result beat it causes.
  function automatic lsm_out_t scan_byte(input lsm_in_t beat);
    lsm_out_t    res;
    logic        is_nl;
    logic        hit;
    int unsigned span;
    int          k;
    res = '0;
    hit = 1'b0;
    is_nl = (beat.text_byte == LSM_NEWLINE);
    span = needle_span();
    if (!is_nl) begin
      for (k = LSM_MAX_NEEDLE_BYTES - 1; k > 0; k--) window_q[k] = window_q[k - 1];
      window_q[0] = to_lower(beat.text_byte);
      if (window_fill < LSM_MAX_NEEDLE_BYTES) window_fill++;
      hit = (window_fill >= span);
      // The newest byte lines up with the last needle byte.
      for (k = 0; k < span; k++) begin
        if (window_q[k] != to_lower(needle_pat[8 * (span - 1 - k) +: 8])) hit = 1'b0;
      end
      if (hit) begin
        if (occ_total != LSM_COUNT_MAX) occ_total++;
        line_hit = 1'b1;
      end
    end
    res.occurrence_here   = hit;
    res.line_finished     = is_nl || beat.end_of_text;
    res.line_had_match    = res.line_finished && line_hit;
    res.line_number       = line_no;
    res.total_occurrences = occ_total;
    // End of text restarts everything; a newline only moves to the next line.
    if (beat.end_of_text) begin
      clear_window();
      line_no = 1;
      occ_total = '0;
      line_hit = 1'b0;
    end else if (is_nl) begin
      clear_window();
      if (line_no != LSM_COUNT_MAX) line_no++;
      line_hit = 1'b0;
    end
    return res;
  endfunction

  // Flip the case of a letter at random.
  function automatic logic [LSM_BYTE_W-1:0] mix_case(input logic [LSM_BYTE_W-1:0] c);
    logic [LSM_BYTE_W-1:0] low;
    low = c | 8'h20;
    if (low >= "a" && low <= "z" && $urandom_range(0, 1) == 1) return c ^ 8'h20;
    return c;
  endfunction

  // Send one text beat after a random gap and record the result it should cause.
  task automatic send_beat(input logic [LSM_BYTE_W-1:0] b, input logic last);
    int unsigned gap;
    lsm_in_t     beat;
    gap = steady ? 0 : $urandom_range(0, 4);
    beat.text_byte   = b;
    beat.end_of_text = last;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_payload <= beat;
    do @(posedge clk); while (in_stall);
    scan_results_due.push_back(scan_byte(beat));
    beats_sent++;
  endtask

  // Stop sending and wait for every outstanding result beat.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (scan_results_due.size() != 0) @(posedge clk);
  endtask

  // Write both needle registers back to back; the block must be idle.
  task automatic write_needle(input logic [LSM_PATTERN_W-1:0] pattern,
                              input logic [LSM_LEN_W-1:0] len);
    logic [LSM_PATTERN_W-1:0] junk;
    junk = {$urandom, $urandom};
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_NEEDLE_PATTERN;
    cfg_data  <= pattern;
    do @(posedge clk); while (!cfg_ready);
    needle_pat = pattern;
    // Bits above the length field are ignored by the register.
    cfg_index <= REG_NEEDLE_LENGTH;
    cfg_data  <= {junk[LSM_PATTERN_W-1:LSM_LEN_W], len};
    do @(posedge clk); while (!cfg_ready);
    needle_size = len;
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Random text: planted needles, needle letters, noise, newlines and text ends.
  task automatic scan_random_text(input int unsigned n_beats);
    int unsigned sent;
    int unsigned span;
    int unsigned roll;
    int unsigned k;
    sent = 0;
    span = needle_span();
    while (sent < n_beats) begin
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
        for (k = 0; k < span; k++) send_beat(mix_case(needle_pat[8 * k +: 8]), 1'b0);
        sent += span;
      end else begin
        if (roll < 37) begin
          send_beat(LSM_NEWLINE, $urandom_range(0, 7) == 0);
        end else if (roll < 41) begin
          send_beat(8'($urandom_range(0, 255)), 1'b1);
        end else if (roll < 72) begin
          send_beat(mix_case(needle_pat[8 * $urandom_range(0, span - 1) +: 8]), 1'b0);
        end else begin
          send_beat(8'($urandom_range(0, 255)), 1'b0);
        end
        sent++;
      end
    end
  endtask

  // The needle after reset is one zero byte.
  task automatic test_reset_needle();
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b1);
    drain_results();
  endtask

  // Case folding, overlapping occurrences, newline limits and a text ending on a newline.
  task automatic test_fold_and_overlap();
    write_needle(64'h4161, 4'd2);
    send_beat("A", 1'b0);
    send_beat("a", 1'b0);
    send_beat("A", 1'b0);
    send_beat(LSM_NEWLINE, 1'b0);
    send_beat("a", 1'b0);
    send_beat(LSM_NEWLINE, 1'b0);
    send_beat("a", 1'b0);
    send_beat(LSM_NEWLINE, 1'b1);
    drain_results();
  endtask

  // A length of zero acts as one, a length above eight acts as eight.
  task automatic test_length_limits();
    write_needle({$urandom, 24'($urandom_range(0, 16777215)), 8'h5A}, 4'd0);
    send_beat("z", 1'b1);
    drain_results();
    write_needle(64'h4867_4665_4463_4261, 4'd15);
    send_beat("A", 1'b0);
    send_beat("b", 1'b0);
    send_beat("C", 1'b0);
    send_beat("d", 1'b0);
    send_beat("E", 1'b0);
    send_beat("f", 1'b0);
    send_beat("G", 1'b0);
    send_beat("h", 1'b1);
    drain_results();
  endtask

  // A needle that holds a newline can never match.
  task automatic test_newline_needle();
    write_needle(64'h0A61, 4'd2);
    send_beat("a", 1'b0);
    send_beat(LSM_NEWLINE, 1'b0);
    send_beat("a", 1'b0);
    send_beat(LSM_NEWLINE, 1'b1);
    drain_results();
  endtask

  // Long receiver hold-off that fills the block, then a sender pause mid-text.
  task automatic test_backpressure();
    write_needle(64'h6261, 4'd2);
    steady = 1'b1;
    hold_left = 60;
    scan_random_text(40);
    steady = 1'b0;
    drain_results();
    scan_random_text(12);
    drain_results();
    scan_random_text(12);
    send_beat(8'($urandom_range(0, 255)), 1'b1);
    drain_results();
  endtask

  // Several needle settings, extremes first, each followed by random text.
  task automatic test_random_needles();
    logic [LSM_PATTERN_W-1:0] pat;
    logic [LSM_LEN_W-1:0]     len;
    int                       ph;
    int                       k;
    for (ph = 0; ph < 8; ph++) begin
      for (k = 0; k < LSM_MAX_NEEDLE_BYTES; k++) begin
        if ($urandom_range(0, 3) == 0) pat[8 * k +: 8] = 8'($urandom_range(0, 255));
        else pat[8 * k +: 8] = mix_case(8'h61 + 8'($urandom_range(0, 2)));
      end
      len = LSM_LEN_W'($urandom_range(1, LSM_MAX_NEEDLE_BYTES));
      case (ph)
        0: begin
          pat = '1;
          len = 4'd1;
        end
        1: begin
          pat = '0;
          len = LSM_LEN_W'(LSM_MAX_NEEDLE_BYTES);
        end
        2: len = 4'd0;
        3: len = 4'd15;
        default: ;
      endcase
      steady = (ph == 5);
      write_needle(pat, len);
      scan_random_text(60);
      drain_results();
    end
    steady = 1'b0;
  endtask

  // Receiver: a random wait after each beat, plus the long hold-off when requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) rx_wait = steady ? 0 : $urandom_range(0, 4);
      else if (rx_wait > 0) rx_wait--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (rx_wait > 0);
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_PRINTED)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Compare each result beat with the oldest prediction.
  always @(posedge clk) begin : check_results
    lsm_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (out_payload.line_finished === 1'b1) lines_ended++;
      if (out_payload.occurrence_here === 1'b1) occurrences_seen++;
      if (scan_results_due.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_PRINTED)
          $display("%0t: result beat with nothing expected, expected none, got %h",
                   $time, out_payload);
      end else begin
        want = scan_results_due.pop_front();
        check_field("occurrence_here", 32'(want.occurrence_here),
                    32'(out_payload.occurrence_here));
        check_field("line_finished", 32'(want.line_finished),
                    32'(out_payload.line_finished));
        check_field("line_had_match", 32'(want.line_had_match),
                    32'(out_payload.line_had_match));
        check_field("line_number", want.line_number, out_payload.line_number);
        check_field("total_occurrences", want.total_occurrences,
                    out_payload.total_occurrences);
      end
    end
  end

  // Watchdog on cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if (in_valid && in_stall) held_cycles++;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_payload = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_NEEDLE_PATTERN;
    cfg_data = '0;
    steady = 1'b0;
    hold_left = 0;
    quiet_cycles = 0;
    fail_count = 0;
    beats_sent = 0;
    lines_ended = 0;
    occurrences_seen = 0;
    settings_used = 1;
    held_cycles = 0;
    needle_pat = '0;
    needle_size = 4'd1;
    clear_window();
    line_no = 1;
    occ_total = '0;
    line_hit = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_needle();
    test_fold_and_overlap();
    test_length_limits();
    test_newline_needle();
    test_backpressure();
    test_random_needles();

    drain_results();
    repeat (8) @(posedge clk);

    $display("Scanned %0d text bytes under %0d needle settings: %0d line ends, %0d occurrences.",
             beats_sent, settings_used, lines_ended, occurrences_seen);
    $display("Input held back for %0d cycles; %0d field mismatches.", held_cycles, fail_count);
    if (fail_count == 0 && scan_results_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* line_substring_matcher.f */
rtl/lsm_pkg.sv
rtl/lsm_front.sv
rtl/lsm_queue.sv
rtl/lsm_back.sv
rtl/line_substring_matcher.sv
rtl/lsm_checker.sv
test/tb.sv
